/* hdl/fsd_pkg.sv */
`default_nettype none

package fsd_pkg;

    localparam logic [2:0] ACT_HEADER    = 3'd0;
    localparam logic [2:0] ACT_RESEND    = 3'd1;
    localparam logic [2:0] ACT_END       = 3'd2;
    localparam logic [2:0] ACT_MAP_RESET = 3'd3;
    localparam logic [2:0] ACT_INIT      = 3'd4;

    localparam logic [7:0]  WRAP_FROM_MIN = 8'd185;
    localparam logic [7:0]  WRAP_TO_MAX   = 8'd70;
    localparam logic [7:0]  BACK_FROM_MAX = 8'd35;
    localparam logic [7:0]  BACK_TO_MIN   = 8'd220;
    localparam logic [31:0] ORD_STEP      = 32'd256;

    typedef enum logic [2:0] {
        OP_HEADER,
        OP_RESEND,
        OP_END,
        OP_MAP_RESET,
        OP_INIT,
        OP_NONE
    } op_t;

    typedef enum logic [2:0] {
        FS_NOT_HEADER,
        FS_BEFORE_FIRST,
        FS_OUT_OF_ORDER,
        FS_DUPLICATE,
        FS_ACCEPTED
    } fstat_t;

    typedef enum logic [1:0] {
        AK_NONE,
        AK_SET,
        AK_RESENDS
    } ack_kind_t;

    typedef enum logic [1:0] {
        OPEN_NONE,
        OPEN_DUP,
        OPEN_ACC
    } open_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        op_t        op;
        logic       first_frame;
        logic [7:0] set_id;
        logic [7:0] original_set;
        logic [7:0] resend_id;
    } cmd_t;

    typedef struct packed {
        fstat_t     frame_status;
        logic       skip_delta;
        logic       ack_id_valid;
        logic [7:0] ack_id;
        ack_kind_t  ack_kind;
        logic [7:0] ack_set;
        logic [8:0] ack_count;
        logic       frame_received;
    } result_t;

endpackage

`default_nettype wire

/* hdl/fsd_front.sv */
`default_nettype none

module fsd_front
    import fsd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,
    input  wire logic [31:0] s_tdata,
    output cmd_t             cmd,
    output logic             cmd_valid,
    input  wire logic        cmd_pop
);

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    cmd_t       in_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        in_cmd.first_frame  = s_tdata[0];
        in_cmd.set_id       = s_tdata[8:1];
        in_cmd.original_set = s_tdata[16:9];
        in_cmd.resend_id    = s_tdata[24:17];
        unique case (s_tuser)
            ACT_HEADER:    in_cmd.op = OP_HEADER;
            ACT_RESEND:    in_cmd.op = OP_RESEND;
            ACT_END:       in_cmd.op = OP_END;
            ACT_MAP_RESET: in_cmd.op = OP_MAP_RESET;
            ACT_INIT:      in_cmd.op = OP_INIT;
            default:       in_cmd.op = OP_NONE;
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = cmd_pop && cmd_valid;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

/* hdl/fsd_back.sv */
`default_nettype none

module fsd_back
    import fsd_pkg::*;
#(
    parameter int SET_RING_DEPTH    = 50,
    parameter int RESEND_RING_DEPTH = 50,
    parameter int MAX_ACKS          = 256
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cmd_t cmd,
    input  wire logic cmd_valid,
    output logic      cmd_pop,
    output result_t   res,
    output logic      res_valid,
    input  wire logic res_ready
);

    localparam int SPW = (SET_RING_DEPTH > 1) ? $clog2(SET_RING_DEPTH) : 1;
    localparam int RPW = (RESEND_RING_DEPTH > 1) ? $clog2(RESEND_RING_DEPTH) : 1;
    localparam int TW  = $clog2(MAX_ACKS + 1);
    localparam int CW  = (TW > 9) ? TW : 9;

    state_t                       state_reg;
    state_t                       state_next;
    cmd_t                         cmd_reg;
    logic                         set_hit_reg;
    logic                         rs_hit_reg;
    logic [31:0]                  ord_reg;
    logic [31:0]                  base_w_reg;
    logic                         lsn_upd_reg;

    logic                         seen_first_reg;
    logic                         seen_first_next;
    logic [7:0]                   last_set_reg;
    logic [7:0]                   last_set_next;
    logic [31:0]                  last_ord_reg;
    logic [31:0]                  last_ord_next;
    logic [31:0]                  base_reg;
    logic [31:0]                  base_next;
    logic [7:0]                   set_mem_reg [SET_RING_DEPTH];
    logic [SET_RING_DEPTH-1:0]    set_vld_reg;
    logic [SPW-1:0]               set_ptr_reg;
    logic [7:0]                   rs_mem_reg [RESEND_RING_DEPTH];
    logic [RESEND_RING_DEPTH-1:0] rs_vld_reg;
    logic [RPW-1:0]               rs_ptr_reg;
    open_t                        open_reg;
    open_t                        open_next;
    logic [7:0]                   open_set_reg;
    logic [7:0]                   open_set_next;
    logic [TW-1:0]                tally_reg;
    logic [TW-1:0]                tally_next;
    logic                         got_reg;
    logic                         got_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    result_t                      out_reg;
    result_t                      out_next;

    logic                         fire;
    logic                         set_push;
    logic                         rs_push;
    logic                         clear_rings;
    logic                         hdr_ok;
    logic [7:0]                   set_key;
    logic                         set_hit;
    logic                         rs_hit;
    logic                         wrap;
    logic                         back;
    logic [31:0]                  adj;
    logic [31:0]                  ord;
    logic [31:0]                  base_w;
    logic [CW-1:0]                tally_wide;

    assign cmd_pop   = (state_reg == ST_IDLE) && cmd_valid;
    assign fire      = (state_reg == ST_EXEC) && (!out_valid_reg || res_ready);
    assign res       = out_reg;
    assign res_valid = out_valid_reg;

    // match against both rings and widen the set number while the item is picked up
    always_comb begin
        set_key = (cmd.op == OP_HEADER) ? cmd.set_id : cmd.original_set;
        set_hit = 1'b0;
        for (int i = 0; i < SET_RING_DEPTH; i++) begin
            set_hit = set_hit | (set_vld_reg[i] && (set_mem_reg[i] == set_key));
        end
        rs_hit = 1'b0;
        for (int i = 0; i < RESEND_RING_DEPTH; i++) begin
            rs_hit = rs_hit | (rs_vld_reg[i] ? (rs_mem_reg[i] == cmd.resend_id)
                                             : (cmd.resend_id == 8'd0));
        end
        wrap   = (last_set_reg > WRAP_FROM_MIN) && (cmd.set_id < WRAP_TO_MAX);
        back   = (last_set_reg < BACK_FROM_MAX) && (cmd.set_id > BACK_TO_MIN);
        base_w = wrap ? (base_reg + ORD_STEP) : base_reg;
        if (wrap && !back) begin
            adj = ORD_STEP;
        end else if (!wrap && back) begin
            adj = 32'd0 - ORD_STEP;
        end else begin
            adj = 32'd0;
        end
        ord = base_reg + {24'd0, cmd.set_id} + adj;
    end

    always_comb begin
        state_next      = state_reg;
        seen_first_next = seen_first_reg;
        last_set_next   = last_set_reg;
        last_ord_next   = last_ord_reg;
        base_next       = base_reg;
        open_next       = open_reg;
        open_set_next   = open_set_reg;
        tally_next      = tally_reg;
        got_next        = got_reg;
        set_push        = 1'b0;
        rs_push         = 1'b0;
        clear_rings     = 1'b0;
        hdr_ok          = 1'b1;
        tally_wide      = CW'(tally_reg);
        out_next        = '0;
        out_valid_next  = out_valid_reg && !res_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    case (cmd_reg.op)
                        OP_HEADER: begin
                            open_next  = OPEN_NONE;
                            tally_next = '0;
                            if (cmd_reg.first_frame) begin
                                seen_first_next = 1'b1;
                            end else if (!seen_first_reg) begin
                                hdr_ok                = 1'b0;
                                out_next.frame_status = FS_BEFORE_FIRST;
                            end else begin
                                base_next = base_w_reg;
                                if (lsn_upd_reg) begin
                                    last_set_next = cmd_reg.set_id;
                                end
                                if (ord_reg < last_ord_reg) begin
                                    hdr_ok                = 1'b0;
                                    out_next.frame_status = FS_OUT_OF_ORDER;
                                end else begin
                                    last_ord_next = ord_reg;
                                end
                            end
                            if (hdr_ok) begin
                                open_set_next = cmd_reg.set_id;
                                if (set_hit_reg) begin
                                    out_next.frame_status = FS_DUPLICATE;
                                    open_next             = OPEN_DUP;
                                end else begin
                                    set_push              = 1'b1;
                                    out_next.frame_status = FS_ACCEPTED;
                                    open_next             = OPEN_ACC;
                                end
                            end
                        end
                        OP_RESEND: begin
                            if (open_reg == OPEN_ACC) begin
                                out_next.skip_delta = set_hit_reg || rs_hit_reg;
                                if (tally_reg < TW'(MAX_ACKS)) begin
                                    out_next.ack_id_valid = 1'b1;
                                    out_next.ack_id       = cmd_reg.resend_id;
                                    tally_next            = tally_reg + 1'b1;
                                end
                                rs_push = 1'b1;
                            end
                        end
                        OP_END: begin
                            if (open_reg != OPEN_NONE) begin
                                out_next.ack_set  = open_set_reg;
                                out_next.ack_kind = AK_SET;
                                if (open_reg == OPEN_ACC) begin
                                    got_next = 1'b1;
                                    if (tally_reg != '0) begin
                                        out_next.ack_kind  = AK_RESENDS;
                                        out_next.ack_count = tally_wide[8:0];
                                    end
                                end
                            end
                            open_next  = OPEN_NONE;
                            tally_next = '0;
                        end
                        OP_MAP_RESET: begin
                            got_next        = 1'b0;
                            seen_first_next = 1'b0;
                            open_next       = OPEN_NONE;
                            tally_next      = '0;
                        end
                        OP_INIT: begin
                            got_next      = 1'b0;
                            clear_rings   = 1'b1;
                            last_set_next = 8'd0;
                            last_ord_next = 32'd0;
                            base_next     = ORD_STEP;
                            open_next     = OPEN_NONE;
                            open_set_next = 8'd0;
                            tally_next    = '0;
                        end
                        default: begin
                        end
                    endcase
                    out_next.frame_received = got_next;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seen_first_reg <= 1'b0;
            last_set_reg   <= 8'd0;
            last_ord_reg   <= 32'd0;
            base_reg       <= ORD_STEP;
            set_vld_reg    <= '0;
            set_ptr_reg    <= '0;
            rs_vld_reg     <= '0;
            rs_ptr_reg     <= '0;
            open_reg       <= OPEN_NONE;
            open_set_reg   <= 8'd0;
            tally_reg      <= '0;
            got_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            seen_first_reg <= seen_first_next;
            last_set_reg   <= last_set_next;
            last_ord_reg   <= last_ord_next;
            base_reg       <= base_next;
            open_reg       <= open_next;
            open_set_reg   <= open_set_next;
            tally_reg      <= tally_next;
            got_reg        <= got_next;
            out_valid_reg  <= out_valid_next;
            if (clear_rings) begin
                set_vld_reg <= '0;
                set_ptr_reg <= '0;
                rs_vld_reg  <= '0;
                rs_ptr_reg  <= '0;
            end else begin
                if (set_push) begin
                    set_vld_reg[set_ptr_reg] <= 1'b1;
                    if (set_ptr_reg == SPW'(SET_RING_DEPTH - 1)) begin
                        set_ptr_reg <= '0;
                    end else begin
                        set_ptr_reg <= set_ptr_reg + 1'b1;
                    end
                end
                if (rs_push) begin
                    rs_vld_reg[rs_ptr_reg] <= 1'b1;
                    if (rs_ptr_reg == RPW'(RESEND_RING_DEPTH - 1)) begin
                        rs_ptr_reg <= '0;
                    end else begin
                        rs_ptr_reg <= rs_ptr_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop) begin
            cmd_reg     <= cmd;
            set_hit_reg <= set_hit;
            rs_hit_reg  <= rs_hit;
            ord_reg     <= ord;
            base_w_reg  <= base_w;
            lsn_upd_reg <= !back;
        end
        if (fire) begin
            out_reg <= out_next;
        end
        if (set_push && !clear_rings) begin
            set_mem_reg[set_ptr_reg] <= cmd_reg.set_id;
        end
        if (rs_push && !clear_rings) begin
            rs_mem_reg[rs_ptr_reg] <= cmd_reg.resend_id;
        end
    end

endmodule

`default_nettype wire

/* hdl/frame_sequence_dedup_ack.sv */
// Receive-side sequence filter for 8-bit frame numbers.
// Input channel s_*: one word per event; s_tuser carries the action
// (header, resent delta, frame end, map reset, full init), s_tdata the
// first-frame flag, set number, original set and resend id.
// Result channel m_*: exactly one word per input word, in order; m_tuser
// carries frame status and ack kind, m_tdata the skip flag, ack id, ack
// set, ack count and the frame-received flag.
// An accepted word waits in the input queue until the back end is idle.
// The back end picks a word from the two-entry input queue and matches it
// against both id rings on pick-up, then updates state and the output
// register once the output is free; it takes no new word before that.
// Both rings are compared in parallel, one valid bit per entry.
// Reset: aresetn low for one clock clears all state; no clearing pass.
// Stall: while m_tready is low the result holds, the back end waits with
// the next word, and the input queue takes up to two more words before
// s_tready drops.
`default_nettype none

module frame_sequence_dedup_ack
    import fsd_pkg::*;
#(
    parameter int SET_RING_DEPTH    = 50,
    parameter int RESEND_RING_DEPTH = 50,
    parameter int MAX_ACKS          = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  s_tuser,   // action
    input  wire logic [31:0] s_tdata,   // first_frame, set_id, original_set, resend_id
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [4:0]       m_tuser,   // frame_status, ack_kind
    output logic [31:0]      m_tdata    // skip_delta, ack_id_valid, ack_id, ack_set,
                                        // ack_count, frame_received
);

    cmd_t    cmd;
    logic    cmd_valid;
    logic    cmd_pop;
    result_t res;

    fsd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    fsd_back #(
        .SET_RING_DEPTH    (SET_RING_DEPTH),
        .RESEND_RING_DEPTH (RESEND_RING_DEPTH),
        .MAX_ACKS          (MAX_ACKS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

    assign m_tuser = {res.ack_kind, res.frame_status};
    assign m_tdata = {4'd0, res.frame_received, res.ack_count, res.ack_set,
                      res.ack_id, res.ack_id_valid, res.skip_delta};

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
`default_nettype none

module testbench;
    import fsd_pkg::*;

    localparam int SET_DEPTH  = 50;
    localparam int RID_DEPTH  = 50;
    localparam int ACK_LIMIT  = 256;
    localparam int RAND_WORDS = 1500;

    localparam logic [2:0] ACT_RSVD_5 = 3'd5;
    localparam logic [2:0] ACT_RSVD_6 = 3'd6;
    localparam logic [2:0] ACT_RSVD_7 = 3'd7;

    localparam result_t QUIET_WORD =
        '{FS_NOT_HEADER, 1'b0, 1'b0, 8'd0, AK_NONE, 8'd0, 9'd0, 1'b0};

    typedef struct packed {
        logic [2:0] op;
        logic       first;
        logic [7:0] sn;
        logic [7:0] orig;
        logic [7:0] rid;
        logic [8:0] reps;
        logic       typed;
        result_t    want;
    } plan_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [2:0]  s_tuser = 3'd0;
    logic [31:0] s_tdata = 32'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [4:0]  m_tuser;
    logic [31:0] m_tdata;

    frame_sequence_dedup_ack #(
        .SET_RING_DEPTH(SET_DEPTH),
        .RESEND_RING_DEPTH(RID_DEPTH),
        .MAX_ACKS(ACK_LIMIT)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tuser(m_tuser),
        .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic        seen_first_q;
    logic [7:0]  last_set_q;
    logic [31:0] last_ord_q;
    logic [31:0] ord_base_q;
    logic        set_hist_ok [SET_DEPTH];
    logic [7:0]  set_hist [SET_DEPTH];
    int          set_hist_ptr;
    logic [7:0]  rid_hist [RID_DEPTH];
    int          rid_hist_ptr;
    open_t       open_q;
    logic [7:0]  open_set_q;
    int          tally_q;
    logic        got_frame_q;

    result_t     due_verdicts [$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          words_checked = 0;
    int          status_count [5] = '{0, 0, 0, 0, 0};
    int          full_lists = 0;
    logic        s_calm = 1'b0;
    logic        m_calm = 1'b0;

    function automatic logic set_known(input logic [7:0] sn);
        for (int i = 0; i < SET_DEPTH; i++) begin
            if (set_hist_ok[i] && set_hist[i] == sn) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic rid_known(input logic [7:0] rid);
        for (int i = 0; i < RID_DEPTH; i++) begin
            if (rid_hist[i] == rid) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic clear_history();
        got_frame_q = 1'b0;
        for (int i = 0; i < SET_DEPTH; i++) begin
            set_hist_ok[i] = 1'b0;
            set_hist[i] = 8'd0;
        end
        for (int i = 0; i < RID_DEPTH; i++) rid_hist[i] = 8'd0;
        set_hist_ptr = 0;
        rid_hist_ptr = 0;
        last_set_q = 8'd0;
        last_ord_q = 32'd0;
        ord_base_q = ORD_STEP;
        open_q = OPEN_NONE;
        open_set_q = 8'd0;
        tally_q = 0;
    endtask

    task automatic classify_word(input logic [2:0] op, input logic first, input logic [7:0] sn,
                                 input logic [7:0] orig, input logic [7:0] rid,
                                 output result_t r);
        logic [31:0] ord;
        r = QUIET_WORD;
        case (op)
            ACT_HEADER: begin
                open_q = OPEN_NONE;
                tally_q = 0;
                if (first) begin
                    seen_first_q = 1'b1;
                end else if (!seen_first_q) begin
                    r.frame_status = FS_BEFORE_FIRST;
                end else begin
                    if (last_set_q > WRAP_FROM_MIN && sn < WRAP_TO_MAX) ord_base_q += ORD_STEP;
                    ord = {24'd0, sn} + ord_base_q;
                    if (last_set_q < BACK_FROM_MAX && sn > BACK_TO_MIN) ord -= ORD_STEP;
                    else last_set_q = sn;
                    if (ord < last_ord_q) r.frame_status = FS_OUT_OF_ORDER;
                    else last_ord_q = ord;
                end
                if (r.frame_status == FS_NOT_HEADER) begin
                    open_set_q = sn;
                    if (set_known(sn)) begin
                        r.frame_status = FS_DUPLICATE;
                        open_q = OPEN_DUP;
                    end else begin
                        set_hist[set_hist_ptr] = sn;
                        set_hist_ok[set_hist_ptr] = 1'b1;
                        set_hist_ptr = (set_hist_ptr + 1) % SET_DEPTH;
                        r.frame_status = FS_ACCEPTED;
                        open_q = OPEN_ACC;
                    end
                end
            end
            ACT_RESEND: begin
                if (open_q == OPEN_ACC) begin
                    r.skip_delta = set_known(orig) || rid_known(rid);
                    if (tally_q < ACK_LIMIT) begin
                        r.ack_id_valid = 1'b1;
                        r.ack_id = rid;
                        tally_q++;
                    end
                    rid_hist[rid_hist_ptr] = rid;
                    rid_hist_ptr = (rid_hist_ptr + 1) % RID_DEPTH;
                end
            end
            ACT_END: begin
                if (open_q != OPEN_NONE) begin
                    r.ack_set = open_set_q;
                    r.ack_kind = AK_SET;
                    if (open_q == OPEN_ACC) begin
                        got_frame_q = 1'b1;
                        if (tally_q != 0) begin
                            r.ack_kind = AK_RESENDS;
                            r.ack_count = 9'(tally_q);
                        end
                    end
                end
                open_q = OPEN_NONE;
                tally_q = 0;
            end
            ACT_MAP_RESET: begin
                got_frame_q = 1'b0;
                seen_first_q = 1'b0;
                open_q = OPEN_NONE;
                tally_q = 0;
            end
            ACT_INIT: clear_history();
            default: ;
        endcase
        r.frame_received = got_frame_q;
    endtask

    task automatic send_word(input logic [2:0] op, input logic first, input logic [7:0] sn,
                             input logic [7:0] orig, input logic [7:0] rid,
                             input logic typed = 1'b0, input result_t want = QUIET_WORD);
        int gap;
        result_t r;
        if ($urandom_range(0, 49) == 0) s_calm = !s_calm;
        gap = s_calm ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser <= op;
        s_tdata <= {7'd0, rid, orig, sn, first};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        classify_word(op, first, sn, orig, rid, r);
        if (op == ACT_HEADER) status_count[r.frame_status]++;
        if (r.ack_kind == AK_RESENDS && r.ack_count == 9'(ACK_LIMIT)) full_lists++;
        due_verdicts.push_back(typed ? want : r);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%t word %0d: %s got %0h, expected %0h", $realtime, words_checked, field,
                 got, want);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.frame_status   = fstat_t'(m_tuser[2:0]);
            got.ack_kind       = ack_kind_t'(m_tuser[4:3]);
            got.skip_delta     = m_tdata[0];
            got.ack_id_valid   = m_tdata[1];
            got.ack_id         = m_tdata[9:2];
            got.ack_set        = m_tdata[17:10];
            got.ack_count      = m_tdata[26:18];
            got.frame_received = m_tdata[27];
            if (due_verdicts.size() == 0) begin
                report_mismatch("unexpected word", {m_tuser, m_tdata[26:0]}, 32'd0);
            end else begin
                want = due_verdicts.pop_front();
                if (got.frame_status !== want.frame_status)
                    report_mismatch("frame_status", 32'(got.frame_status),
                                    32'(want.frame_status));
                if (got.skip_delta !== want.skip_delta)
                    report_mismatch("skip_delta", 32'(got.skip_delta), 32'(want.skip_delta));
                if (got.ack_id_valid !== want.ack_id_valid)
                    report_mismatch("ack_id_valid", 32'(got.ack_id_valid),
                                    32'(want.ack_id_valid));
                if (got.ack_id !== want.ack_id)
                    report_mismatch("ack_id", 32'(got.ack_id), 32'(want.ack_id));
                if (got.ack_kind !== want.ack_kind)
                    report_mismatch("ack_kind", 32'(got.ack_kind), 32'(want.ack_kind));
                if (got.ack_set !== want.ack_set)
                    report_mismatch("ack_set", 32'(got.ack_set), 32'(want.ack_set));
                if (got.ack_count !== want.ack_count)
                    report_mismatch("ack_count", 32'(got.ack_count), 32'(want.ack_count));
                if (got.frame_received !== want.frame_received)
                    report_mismatch("frame_received", 32'(got.frame_received),
                                    32'(want.frame_received));
            end
            words_checked++;
        end
    end

    initial begin
        int gap;
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 49) == 0) m_calm = !m_calm;
            gap = m_calm ? 0 : $urandom_range(0, 7);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        plan_row_t   plan [27];
        logic [7:0]  cur_set;
        logic [7:0]  hdr_set;
        logic [7:0]  next_rid;
        logic [7:0]  orig;
        logic [7:0]  rid;
        logic        first;
        logic        want_first;
        int          pick;
        int          roll;
        int          n;
        int          stop_at;

        plan = '{
            '{ACT_RESEND,    1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b1, QUIET_WORD},
            '{ACT_END,       1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b1, QUIET_WORD},
            '{ACT_HEADER,    1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b1,
              '{FS_BEFORE_FIRST, 1'b0, 1'b0, 8'd0, AK_NONE, 8'd0, 9'd0, 1'b0}},
            '{ACT_END,       1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b1, QUIET_WORD},
            '{ACT_RSVD_5,    1'b1, 8'hff,  8'hff,  8'hff,  9'd1,   1'b1, QUIET_WORD},
            '{ACT_RSVD_6,    1'b1, 8'hff,  8'hff,  8'hff,  9'd1,   1'b1, QUIET_WORD},
            '{ACT_RSVD_7,    1'b0, 8'h00,  8'h00,  8'h00,  9'd1,   1'b1, QUIET_WORD},
            '{ACT_HEADER,    1'b1, 8'd255, 8'd0,   8'd0,   9'd1,   1'b1,
              '{FS_ACCEPTED, 1'b0, 1'b0, 8'd0, AK_NONE, 8'd0, 9'd0, 1'b0}},
            '{ACT_RESEND,    1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b1,
              '{FS_NOT_HEADER, 1'b1, 1'b1, 8'd0, AK_NONE, 8'd0, 9'd0, 1'b0}},
            '{ACT_RESEND,    1'b0, 8'd0,   8'd255, 8'd255, 9'd1,   1'b1,
              '{FS_NOT_HEADER, 1'b1, 1'b1, 8'd255, AK_NONE, 8'd0, 9'd0, 1'b0}},
            '{ACT_RESEND,    1'b0, 8'd0,   8'd170, 8'd170, 9'd1,   1'b1,
              '{FS_NOT_HEADER, 1'b0, 1'b1, 8'd170, AK_NONE, 8'd0, 9'd0, 1'b0}},
            '{ACT_END,       1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b1,
              '{FS_NOT_HEADER, 1'b0, 1'b0, 8'd0, AK_RESENDS, 8'd255, 9'd3, 1'b1}},
            '{ACT_HEADER,    1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_HEADER,    1'b0, 8'd255, 8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_END,       1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_HEADER,    1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_RESEND,    1'b0, 8'd0,   8'd85,  8'd85,  9'd1,   1'b0, QUIET_WORD},
            '{ACT_END,       1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_HEADER,    1'b0, 8'd200, 8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_HEADER,    1'b0, 8'd10,  8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_RESEND,    1'b0, 8'd0,   8'd85,  8'd3,   9'd260, 1'b0, QUIET_WORD},
            '{ACT_END,       1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_MAP_RESET, 1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_HEADER,    1'b0, 8'd11,  8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_INIT,      1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_HEADER,    1'b1, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD},
            '{ACT_END,       1'b0, 8'd0,   8'd0,   8'd0,   9'd1,   1'b0, QUIET_WORD}
        };

        clear_history();
        seen_first_q = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            repeat (plan[i].reps)
                send_word(plan[i].op, plan[i].first, plan[i].sn, plan[i].orig, plan[i].rid,
                          plan[i].typed, plan[i].want);
        end

        cur_set = 8'd1;
        next_rid = 8'd0;
        want_first = 1'b0;
        stop_at = words_sent + RAND_WORDS;
        while (words_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    cur_set = cur_set + 8'($urandom_range(0, 12));
                    hdr_set = cur_set;
                end else if (roll < 88) begin
                    hdr_set = cur_set - 8'($urandom_range(0, 2));
                end else if (roll < 96) begin
                    hdr_set = cur_set - 8'($urandom_range(3, 60));
                end else begin
                    cur_set = 8'($urandom);
                    hdr_set = cur_set;
                end
                first = want_first ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 29) == 0);
                if (first) want_first = 1'b0;
                send_word(ACT_HEADER, first, hdr_set, 8'($urandom), 8'($urandom));
                n = ($urandom_range(0, 99) == 0) ? $urandom_range(250, 270)
                                                 : $urandom_range(0, 6);
                repeat (n) begin
                    roll = $urandom_range(0, 9);
                    orig = (roll < 3) ? cur_set - 8'($urandom_range(0, 3)) : 8'($urandom);
                    if (roll < 6) begin
                        rid = next_rid;
                        next_rid++;
                    end else if (roll < 9) begin
                        rid = next_rid - 8'($urandom_range(1, 60));
                    end else begin
                        rid = 8'($urandom);
                    end
                    send_word(ACT_RESEND, 1'($urandom), 8'($urandom), orig, rid);
                end
                if ($urandom_range(0, 9) != 0)
                    send_word(ACT_END, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 95) begin
                send_word(($urandom_range(0, 1) != 0) ? ACT_RESEND : ACT_END, 1'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom));
            end else if (pick < 98) begin
                send_word(ACT_MAP_RESET, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                want_first = 1'b1;
            end else begin
                send_word(ACT_INIT, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        while (due_verdicts.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Sent %0d words, checked %0d: headers %0d accepted, %0d duplicate,",
                 words_sent, words_checked, status_count[FS_ACCEPTED],
                 status_count[FS_DUPLICATE]);
        $display("%0d out of order, %0d before first marker; %0d saturated ack lists",
                 status_count[FS_OUT_OF_ORDER], status_count[FS_BEFORE_FIRST], full_lists);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
